// ===== hdl/range_add_range_min_tree_core_macros.svh =====
// Assertion macros for the range-add range-minimum tree core
`ifndef RANGE_ADD_RANGE_MIN_TREE_CORE_MACROS_SVH
`define RANGE_ADD_RANGE_MIN_TREE_CORE_MACROS_SVH

// same-cycle implication
`define RARMT_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define RARMT_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/rarmt_pkg.sv =====
// Types, constants and helpers for the range-add range-minimum tree core
package rarmt_pkg;

    localparam int LOG_LEAVES = 10;
    localparam int NODE_W     = 32;
    localparam int RANGE_W    = 10;
    localparam int DEPTH_W    = 4;
    localparam int ADDR_W     = LOG_LEAVES;
    localparam int WORD_COUNT = 1 << LOG_LEAVES;
    localparam int POS_W      = LOG_LEAVES + 2;
    localparam int WORD_W     = 4 * NODE_W;

    localparam logic [NODE_W-1:0] EMPTY_MIN = 32'h3f3f3f3f;

    localparam logic [1:0] ACT_QUERY = 2'd0;
    localparam logic [1:0] ACT_ADD   = 2'd1;
    localparam logic [1:0] ACT_CLEAR = 2'd2;

    typedef struct packed {
        logic [NODE_W-1:0] min_v;
        logic [NODE_W-1:0] pend;
    } node_t;

    // one memory word holds the two children of one parent
    typedef node_t [1:0] word_t;

    typedef struct packed {
        logic              found;
        logic [NODE_W-1:0] val;
    } acc_t;

    typedef struct packed {
        logic              valid;
        logic [ADDR_W-1:0] node;
        logic [NODE_W-1:0] val;
    } upd_t;

    typedef enum logic [6:0] {
        S_CLEAR = 7'b0000001,
        S_IDLE  = 7'b0000010,
        S_RD_A  = 7'b0000100,
        S_RD_B  = 7'b0001000,
        S_WR_A  = 7'b0010000,
        S_WR_B  = 7'b0100000,
        S_DONE  = 7'b1000000
    } state_t;

    function automatic logic [NODE_W-1:0] s_min(logic [NODE_W-1:0] a, logic [NODE_W-1:0] b);
        return ($signed(b) < $signed(a)) ? b : a;
    endfunction

    function automatic logic [NODE_W-1:0] node_sum(node_t n);
        return n.min_v + n.pend;
    endfunction

    // left operand first
    function automatic acc_t acc_comb(acc_t a, acc_t b);
        acc_t r;
        r.found = a.found | b.found;
        if (a.found && b.found)
        begin
            r.val = s_min(a.val, b.val);
        end
        else if (a.found)
        begin
            r.val = a.val;
        end
        else
        begin
            r.val = b.val;
        end
        return r;
    endfunction

endpackage

// ===== hdl/rarmt_ram.sv =====
// Generic simple dual-port RAM with registered read
module rarmt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== hdl/range_add_range_min_tree_core.sv =====
// Range-add range-minimum tree core: bottom-up walk over a node memory
//
//  channel   direction  handshake                  payload
//  cmd       in         cmd_valid / cmd_ready      action, range_from, range_to, add_value
//  rsp       out        rsp_valid / rsp_ready      min_value
//  cfg       in         cfg_we                     cfg_wdata (depth_in_use)
//
// One memory word per parent holds both children; each tree level passes through
// two reads and two writes on the single read and write ports; a query does not write.
// Query and add walk d+1 tree levels, d the clamped depth.
// Clear sweeps 1024 words, one a cycle; the same pass runs after reset.
// A query result waits in the output register; a further request is taken meanwhile.
module range_add_range_min_tree_core
    import rarmt_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cmd_valid,
    output logic                      cmd_ready,
    input  logic [1:0]                action,
    input  logic [RANGE_W-1:0]        range_from,
    input  logic [RANGE_W-1:0]        range_to,
    input  logic signed [NODE_W-1:0]  add_value,
    output logic                      rsp_valid,
    input  logic                      rsp_ready,
    output logic signed [NODE_W-1:0]  min_value,
    input  logic                      cfg_we,
    input  logic [DEPTH_W-1:0]        cfg_wdata
);

`include "range_add_range_min_tree_core_macros.svh"

    state_t             state_reg, state_next;
    logic [DEPTH_W-1:0] depth_reg;
    logic [ADDR_W-1:0]  clr_reg;
    logic               add_reg;
    logic               empty_reg;
    logic [NODE_W-1:0]  x_reg;
    logic [POS_W-1:0]   n_reg, cl_reg, cr_reg;
    logic [DEPTH_W-1:0] lvl_reg;
    acc_t               accl_reg, accr_reg, accl1_reg, accr1_reg;
    logic [NODE_W-1:0]  vl_reg, vr_reg;
    logic               tl_reg, tr_reg;
    word_t              wa_reg, wa_mod_reg, wb_mod_reg;
    upd_t               updl_reg, updr_reg;
    logic               rsp_valid_reg;
    logic [NODE_W-1:0]  min_reg;

    logic               ram_we;
    logic [ADDR_W-1:0]  ram_waddr, ram_raddr;
    logic [WORD_W-1:0]  ram_wdata, ram_rdata;
    word_t              rword;

    logic [DEPTH_W-1:0] d_eff;
    logic [POS_W-1:0]   n_w, from_e, to_e, to_c;
    logic [ADDR_W-1:0]  a_idx, b_idx;
    logic               same_ab, eq_c, tl, tr;
    logic [POS_W-1:0]   cl_post;
    word_t              wa_mod, wb_base, wb_mod;
    acc_t               accl1, accr1, accm, fin;
    word_t              src_l;

    function automatic word_t patch(word_t w, logic [ADDR_W-1:0] idx, upd_t ul, upd_t ur);
        word_t r;
        r = w;
        if (ul.valid && ({1'b0, ul.node[ADDR_W-1:1]} == idx))
        begin
            r[ul.node[0]].min_v = ul.val;
        end
        if (ur.valid && ({1'b0, ur.node[ADDR_W-1:1]} == idx))
        begin
            r[ur.node[0]].min_v = ur.val;
        end
        return r;
    endfunction

    rarmt_ram #(.WIDTH(WORD_W), .DEPTH(WORD_COUNT)) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rword   = word_t'(ram_rdata);
    assign d_eff   = (depth_reg > DEPTH_W'(LOG_LEAVES)) ? DEPTH_W'(LOG_LEAVES) : depth_reg;
    assign n_w     = POS_W'(1) << d_eff;
    assign from_e  = POS_W'(range_from);
    assign to_e    = POS_W'(range_to);
    assign to_c    = (to_e >= n_w) ? (n_w - POS_W'(1)) : to_e;
    assign a_idx   = cl_reg[ADDR_W:1];
    assign b_idx   = cr_reg[ADDR_W:1];
    assign same_ab = (a_idx == b_idx);
    assign eq_c    = (cl_reg == cr_reg);

    always_comb
    begin
        tl = !empty_reg && !cl_reg[0]
             && (({1'b0, cl_reg} + (POS_W+1)'(2)) <= {1'b0, cr_reg});
        cl_post = cl_reg + POS_W'(tl);
        tr = !empty_reg && cr_reg[0]
             && (({1'b0, cl_post} + (POS_W+1)'(2)) <= {1'b0, cr_reg});
        wa_mod = wa_reg;
        if (tl && add_reg)
        begin
            wa_mod[1].pend = wa_reg[1].pend + x_reg;
        end
        wb_base = same_ab ? wa_mod : patch(rword, b_idx, updl_reg, updr_reg);
        wb_mod = wb_base;
        if (tr && add_reg)
        begin
            wb_mod[0].pend = wb_base[0].pend + x_reg;
        end
        accm = acc_comb(accl_reg, accr_reg);
        if (eq_c)
        begin
            accl1.found = accm.found;
            accl1.val   = accm.val + wa_reg[cl_reg[0]].pend;
            accr1.found = 1'b0;
            accr1.val   = accr_reg.val;
        end
        else
        begin
            accl1.found = accl_reg.found;
            accl1.val   = accl_reg.val + wa_reg[cl_reg[0]].pend;
            accr1.found = accr_reg.found;
            accr1.val   = accr_reg.val + wb_base[cr_reg[0]].pend;
        end
        src_l = same_ab ? wb_mod_reg : wa_mod_reg;
        fin = acc_comb(accl_reg, accr_reg);
    end

    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = b_idx;
        ram_wdata = WORD_W'(wb_mod_reg);
        ram_raddr = (state_reg == S_RD_A) ? a_idx : b_idx;
        case (state_reg)
            S_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                ram_wdata = '0;
            end
            S_WR_A:
            begin
                ram_we    = add_reg;
                ram_waddr = a_idx;
                ram_wdata = WORD_W'(wa_mod);
            end
            S_WR_B:
            begin
                ram_we    = add_reg;
            end
            default:
            begin
                ram_we    = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:
            begin
                if (clr_reg == ADDR_W'(WORD_COUNT - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    if (action == ACT_QUERY || action == ACT_ADD)
                    begin
                        state_next = S_RD_A;
                    end
                    else if (action == ACT_CLEAR)
                    begin
                        state_next = S_CLEAR;
                    end
                end
            end
            S_RD_A: state_next = S_RD_B;
            S_RD_B: state_next = S_WR_A;
            S_WR_A: state_next = S_WR_B;
            S_WR_B:
            begin
                if (lvl_reg != '0)
                begin
                    state_next = S_RD_A;
                end
                else
                begin
                    state_next = add_reg ? S_IDLE : S_DONE;
                end
            end
            S_DONE:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            depth_reg     <= DEPTH_W'(LOG_LEAVES);
            clr_reg       <= '0;
            rsp_valid_reg <= 1'b0;
            updl_reg      <= '0;
            updr_reg      <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                depth_reg <= cfg_wdata;
            end
            if (state_reg == S_CLEAR)
            begin
                clr_reg <= clr_reg + ADDR_W'(1);
            end
            if (rsp_valid_reg && rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
            if (state_reg == S_DONE && (!rsp_valid_reg || rsp_ready))
            begin
                rsp_valid_reg <= 1'b1;
            end
            if (state_reg == S_IDLE)
            begin
                updl_reg <= '0;
                updr_reg <= '0;
            end
            if (state_reg == S_WR_B)
            begin
                updl_reg.valid <= add_reg && (a_idx != '0) && (POS_W'(a_idx) < n_reg);
                updl_reg.node  <= a_idx;
                updl_reg.val   <= s_min(node_sum(src_l[0]), node_sum(src_l[1]));
                updr_reg.valid <= add_reg && (b_idx != '0) && (POS_W'(b_idx) < n_reg);
                updr_reg.node  <= b_idx;
                updr_reg.val   <= s_min(node_sum(wb_mod_reg[0]), node_sum(wb_mod_reg[1]));
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                add_reg   <= (action == ACT_ADD);
                x_reg     <= add_value;
                n_reg     <= n_w;
                empty_reg <= (from_e >= n_w);
                cl_reg    <= n_w + from_e - POS_W'(1);
                cr_reg    <= n_w + to_c + POS_W'(1);
                lvl_reg   <= d_eff;
                accl_reg  <= '0;
                accr_reg  <= '0;
            end
            S_RD_B:
            begin
                wa_reg <= patch(rword, a_idx, updl_reg, updr_reg);
            end
            S_WR_A:
            begin
                wa_mod_reg <= wa_mod;
                wb_mod_reg <= wb_mod;
                accl1_reg  <= accl1;
                accr1_reg  <= accr1;
                vl_reg     <= node_sum(wa_reg[1]);
                vr_reg     <= node_sum(wb_base[0]);
                tl_reg     <= tl;
                tr_reg     <= tr;
                cl_reg     <= cl_post;
                cr_reg     <= cr_reg - POS_W'(tr);
            end
            S_WR_B:
            begin
                accl_reg <= tl_reg ? acc_comb(accl1_reg, '{found: 1'b1, val: vl_reg}) : accl1_reg;
                accr_reg <= tr_reg ? acc_comb('{found: 1'b1, val: vr_reg}, accr1_reg) : accr1_reg;
                cl_reg   <= cl_reg >> 1;
                cr_reg   <= cr_reg >> 1;
                lvl_reg  <= lvl_reg - DEPTH_W'(1);
            end
            S_DONE:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    min_reg <= fin.found ? fin.val : EMPTY_MIN;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign cmd_ready = (state_reg == S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign min_value = min_reg;

    `RARMT_ASSERT_IMP(a_query_no_write, (!add_reg && (state_reg == S_WR_A || state_reg == S_WR_B)), !ram_we, "query wrote node memory")
    `RARMT_ASSERT_IMP(a_rsp_from_done, $rose(rsp_valid), $past(state_reg == S_DONE), "response without finished query")
    `RARMT_ASSERT_NXT(a_clear_holds, (state_reg == S_CLEAR && clr_reg != ADDR_W'(WORD_COUNT - 1)), state_reg == S_CLEAR, "clear sweep cut short")
    `RARMT_ASSERT_IMP(a_level_range, (state_reg == S_RD_A), lvl_reg <= DEPTH_W'(LOG_LEAVES), "walk level out of range")

endmodule
